>>> hdl/thc_pkg.sv
// Shared types and constants for the temperature/humidity compensation block.
// Every other file in hdl/ depends on this package.
package thc_pkg;

    localparam int RAW_W      = 16;
    localparam int TDEG_W     = 8;
    localparam int HPCT_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FINE_W     = 24;
    localparam int WORD_W     = 32;
    localparam int MAG_W      = 14;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_ONE   = 3'd0,
        REG_TEMP_TWO   = 3'd1,
        REG_TEMP_THREE = 3'd2,
        REG_HUM_ONE    = 3'd3,
        REG_HUM_TWO    = 3'd4,
        REG_HUM_FOUR   = 3'd5,
        REG_HUM_FIVE   = 3'd6,
        REG_HUM_SIX    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [15:0] temp_one;
        logic signed [15:0] temp_two;
        logic signed [15:0] temp_three;
        logic        [7:0]  hum_one;
        logic signed [15:0] hum_two;
        logic signed [11:0] hum_four;
        logic signed [11:0] hum_five;
        logic signed [7:0]  hum_six;
    } coeff_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
        ST_H9, ST_H10, ST_H11, ST_H12,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t state;
        logic   in_ready;
        logic   out_load;
    } ctrl_t;

    localparam word_t TEMP_ROUND   = 32'sd128;
    localparam word_t DIV100_RECIP = 32'sd5243;
    localparam int    DIV100_SHIFT = 19;
    localparam word_t T_HI_LIM     = 32'sd8600;
    localparam word_t T_LO_LIM     = -32'sd4100;
    localparam logic signed [TDEG_W-1:0] DEG_MAX = 8'sd85;
    localparam logic signed [TDEG_W-1:0] DEG_MIN = -8'sd40;
    localparam word_t X_OFFSET     = 32'sd76800;
    localparam word_t A_ROUND      = 32'sd16384;
    localparam word_t C_BIAS       = 32'sd32768;
    localparam word_t E_BIAS       = 32'sd2097152;
    localparam word_t F_ROUND      = 32'sd8192;
    localparam word_t V_MAX        = 32'sd419430400;
    localparam logic [HPCT_W-1:0] PCT_MAX = 7'd100;

    localparam coeff_t COEFF_RESET = '{
        temp_one:   16'd28326,
        temp_two:   16'sd26604,
        temp_three: 16'sd12850,
        hum_one:    8'd75,
        hum_two:    16'sd383,
        hum_four:   12'sd271,
        hum_five:   12'sd50,
        hum_six:    8'sd30
    };

endpackage

>>> hdl/thc_if.sv
// Channel interfaces: raw sample input, compensated result output, register writes.
// Depends on thc_pkg.
interface thc_sample_if;
    import thc_pkg::*;
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_temperature;
    logic [RAW_W-1:0]  raw_humidity;
    modport source (output valid, output raw_temperature, output raw_humidity, input ready);
    modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface thc_result_if;
    import thc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TDEG_W-1:0] temperature_deg;
    logic        [HPCT_W-1:0] humidity_percent;
    modport source (output valid, output temperature_deg, output humidity_percent, input ready);
    modport sink   (input valid, input temperature_deg, input humidity_percent, output ready);
endinterface

interface thc_cfg_if;
    import thc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/temp_humidity_compensation.sv
// Temperature/humidity compensation top level; uses thc_pkg, thc_if, thc_cfg_regs,
// thc_seq and thc_datapath.
// After accept, ST_T1..ST_T8 run if raw temperature is nonzero, then ST_H0..ST_H12
// if raw humidity is nonzero; ST_DONE loads the result once the output is free.
// New samples are taken only in ST_IDLE; all steps share one 32x32 multiplier.
// Reset: coefficients return to calibration defaults, fine temperature clears to 0.
module temp_humidity_compensation #(
    parameter int HUM_COEFF_THREE = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    thc_cfg_if.sink       cfg,
    thc_sample_if.sink    sample,
    thc_result_if.source  result
);
    import thc_pkg::*;

    coeff_t coeff;
    ctrl_t  ctrl;
    logic   start;
    logic   out_free;
    logic   out_valid_reg, out_valid_next;
    logic signed [TDEG_W-1:0] deg, deg_out_reg;
    logic [HPCT_W-1:0]        pct, pct_out_reg;

    assign sample.ready = ctrl.in_ready;
    assign start        = sample.valid && ctrl.in_ready;
    assign out_free     = !out_valid_reg || result.ready;

    thc_cfg_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coeff (coeff)
    );

    thc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .rt_nz    (sample.raw_temperature != '0),
        .rh_nz    (sample.raw_humidity != '0),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    thc_datapath #(
        .HUM_COEFF_THREE (HUM_COEFF_THREE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .coeff           (coeff),
        .start           (start),
        .raw_temperature (sample.raw_temperature),
        .raw_humidity    (sample.raw_humidity),
        .deg             (deg),
        .pct             (pct)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            deg_out_reg <= deg;
            pct_out_reg <= pct;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.temperature_deg  = deg_out_reg;
    assign result.humidity_percent = pct_out_reg;

endmodule

>>> hdl/thc_cfg_regs.sv
// Calibration coefficient registers, written through the configuration channel.
// Depends on thc_pkg and thc_cfg_if.
module thc_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    thc_cfg_if.sink         cfg,
    output thc_pkg::coeff_t coeff
);
    import thc_pkg::*;

    coeff_t coeff_reg;
    coeff_t coeff_next;

    assign cfg.ready = 1'b1;
    assign coeff     = coeff_reg;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_TEMP_ONE:   coeff_next.temp_one   = cfg.data;
                REG_TEMP_TWO:   coeff_next.temp_two   = cfg.data;
                REG_TEMP_THREE: coeff_next.temp_three = cfg.data;
                REG_HUM_ONE:    coeff_next.hum_one    = cfg.data[7:0];
                REG_HUM_TWO:    coeff_next.hum_two    = cfg.data;
                REG_HUM_FOUR:   coeff_next.hum_four   = cfg.data[11:0];
                REG_HUM_FIVE:   coeff_next.hum_five   = cfg.data[11:0];
                REG_HUM_SIX:    coeff_next.hum_six    = cfg.data[7:0];
                default:        coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coeff_reg <= COEFF_RESET;
        else
            coeff_reg <= coeff_next;
    end

endmodule

>>> hdl/thc_seq.sv
// Step sequencer: walks the temperature and humidity steps of one item.
// Depends on thc_pkg.
module thc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           rt_nz,
    input  logic           rh_nz,
    input  logic           out_free,
    output thc_pkg::ctrl_t ctrl
);
    import thc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rh_nz_reg;
    logic   rh_nz_next;

    always_comb
    begin
        state_next = state_reg;
        rh_nz_next = rh_nz_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rh_nz_next = rh_nz;
                    if (rt_nz)
                        state_next = ST_T1;
                    else if (rh_nz)
                        state_next = ST_H0;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_T8:   state_next = rh_nz_reg ? ST_H0 : ST_DONE;
            ST_H12:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = state_t'(state_reg + 5'd1);
        endcase
    end

    always_comb
    begin
        ctrl.state    = state_reg;
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.out_load = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rh_nz_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rh_nz_reg <= rh_nz_next;
        end
    end

endmodule

>>> hdl/thc_datapath.sv
// Shared 32x32 wrapping multiplier, working registers and fine temperature state.
// Depends on thc_pkg; steps are chosen by thc_seq.
module thc_datapath #(
    parameter int HUM_COEFF_THREE = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  thc_pkg::ctrl_t                      ctrl,
    input  thc_pkg::coeff_t                     coeff,
    input  logic                                start,
    input  logic [thc_pkg::RAW_W-1:0]           raw_temperature,
    input  logic [thc_pkg::RAW_W-1:0]           raw_humidity,
    output logic signed [thc_pkg::TDEG_W-1:0]   deg,
    output logic [thc_pkg::HPCT_W-1:0]          pct
);
    import thc_pkg::*;

    localparam word_t HC3 = word_t'(HUM_COEFF_THREE);

    logic signed [RAW_W:0]  d_reg, d_next;
    logic [RAW_W-1:0]       rh_reg, rh_next;
    logic signed [FINE_W-1:0] fine_reg, fine_next;
    word_t                  p_reg, p_next;
    word_t                  x_reg, x_next;
    word_t                  w0_reg, w0_next;
    word_t                  w1_reg, w1_next;
    word_t                  w2_reg, w2_next;
    word_t                  w3_reg, w3_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   hi_reg, hi_next;
    logic                   lo_reg, lo_next;
    logic signed [TDEG_W-1:0] deg_reg, deg_next;
    logic [HPCT_W-1:0]      pct_reg, pct_next;

    word_t mul_a, mul_b;
    word_t fine32, dw, tsum, vdiff, negw1;
    logic [HPCT_W-1:0] quot;

    assign fine32 = word_t'(fine_reg);
    assign dw     = word_t'(d_reg);
    assign tsum   = (fine32 <<< 2) + fine32 + TEMP_ROUND;
    assign negw1  = -w1_reg;
    assign vdiff  = w0_reg - (p_reg >>> 4);
    assign quot   = p_reg[DIV100_SHIFT+HPCT_W-1:DIV100_SHIFT];
    assign p_next = mul_a * mul_b;

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        d_next    = d_reg;
        rh_next   = rh_reg;
        fine_next = fine_reg;
        x_next    = x_reg;
        w0_next   = w0_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        w3_next   = w3_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        deg_next  = deg_reg;
        pct_next  = pct_reg;
        unique case (ctrl.state)
            ST_IDLE:
            begin
                if (start)
                begin
                    d_next   = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.temp_one});
                    rh_next  = raw_humidity;
                    deg_next = '0;
                    pct_next = '0;
                end
            end
            ST_T1:
            begin
                mul_a = dw <<< 1;
                mul_b = word_t'(coeff.temp_two);
            end
            ST_T2:
            begin
                w0_next = p_reg >>> 11;
                mul_a   = dw;
                mul_b   = dw;
            end
            ST_T3:
            begin
                mul_a = p_reg >>> 12;
                mul_b = word_t'(coeff.temp_three);
            end
            ST_T4:   fine_next = FINE_W'(w0_reg + (p_reg >>> 14));
            ST_T5:   w1_next = tsum >>> 8;
            ST_T6:
            begin
                hi_next  = (w1_reg >= T_HI_LIM);
                lo_next  = (w1_reg <= T_LO_LIM);
                neg_next = w1_reg[WORD_W-1];
                mag_next = w1_reg[WORD_W-1] ? negw1[MAG_W-1:0] : w1_reg[MAG_W-1:0];
            end
            ST_T7:
            begin
                mul_a = word_t'(mag_reg);
                mul_b = DIV100_RECIP;
            end
            ST_T8:
            begin
                priority if (hi_reg)
                    deg_next = DEG_MAX;
                else if (lo_reg)
                    deg_next = DEG_MIN;
                else if (neg_reg)
                    deg_next = -$signed(TDEG_W'(quot));
                else
                    deg_next = $signed(TDEG_W'(quot));
            end
            ST_H0:
            begin
                x_next  = fine32 - X_OFFSET;
                w3_next = (word_t'(rh_reg) <<< 14) - (word_t'(coeff.hum_four) <<< 20);
            end
            ST_H1:
            begin
                mul_a = word_t'(coeff.hum_five);
                mul_b = x_reg;
            end
            ST_H2:
            begin
                w0_next = w3_reg - p_reg;
                mul_a   = x_reg;
                mul_b   = word_t'(coeff.hum_six);
            end
            ST_H3:
            begin
                w0_next = (w0_reg + A_ROUND) >>> 15;
                w1_next = p_reg >>> 10;
                mul_a   = x_reg;
                mul_b   = HC3;
            end
            ST_H4:   w2_next = (p_reg >>> 11) + C_BIAS;
            ST_H5:
            begin
                mul_a = w1_reg;
                mul_b = w2_reg;
            end
            ST_H6:   w1_next = (p_reg >>> 10) + E_BIAS;
            ST_H7:
            begin
                mul_a = w1_reg;
                mul_b = word_t'(coeff.hum_two);
            end
            ST_H8:   w1_next = (p_reg + F_ROUND) >>> 14;
            ST_H9:
            begin
                mul_a = w0_reg;
                mul_b = w1_reg;
            end
            ST_H10:
            begin
                w0_next = p_reg;
                mul_a   = p_reg >>> 15;
                mul_b   = p_reg >>> 15;
            end
            ST_H11:
            begin
                mul_a = p_reg >>> 7;
                mul_b = word_t'(coeff.hum_one);
            end
            ST_H12:
            begin
                priority if (vdiff[WORD_W-1])
                    pct_next = '0;
                else if (vdiff > V_MAX)
                    pct_next = PCT_MAX;
                else
                    pct_next = vdiff[22+HPCT_W-1:22];
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fine_reg <= '0;
        else
            fine_reg <= fine_next;
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        rh_reg  <= rh_next;
        p_reg   <= p_next;
        x_reg   <= x_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        w2_reg  <= w2_next;
        w3_reg  <= w3_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        deg_reg <= deg_next;
        pct_reg <= pct_next;
    end

    assign deg = deg_reg;
    assign pct = pct_reg;

endmodule
